### hw/rtl/quaternion_vector_rotate_defines.svh
// ---------------------------------------------------------------------------
// Quaternion vector rotate assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off while in reset.
// ---------------------------------------------------------------------------
`ifndef QUATERNION_VECTOR_ROTATE_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATE_DEFINES_SVH

// Same-cycle implication
`define QVR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define QVR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/qvr_pkg.sv
// ---------------------------------------------------------------------------
// Quaternion vector rotate package
// Shared constants and register codes.
// ---------------------------------------------------------------------------
package qvr_pkg;

    localparam int QVR_DATA_WIDTH = 16;
    // root extraction works on a fixed 64-bit radicand
    localparam int QVR_SQ_W       = 64;
    localparam int QVR_ISQ_N      = QVR_SQ_W / 2;
    localparam int QVR_R_W        = QVR_SQ_W / 2;
    // radicand is scaled up by an even power 2*hk, hk up to this
    localparam int QVR_HK_MAX     = 30;
    localparam int QVR_HK_W       = 5;
    localparam int QVR_ADDR_W     = 4;
    localparam int QVR_APB_W      = 32;

    localparam logic [1:0] QVR_REG_QW = 2'd0;
    localparam logic [1:0] QVR_REG_QX = 2'd1;
    localparam logic [1:0] QVR_REG_QY = 2'd2;
    localparam logic [1:0] QVR_REG_QZ = 2'd3;

endpackage

### hw/rtl/qvr_norm.sv
// ---------------------------------------------------------------------------
// Vector normalizer
// Sum of squares, pipelined integer square root and restoring division.
// ---------------------------------------------------------------------------
module qvr_norm import qvr_pkg::*; #(
    parameter int DATA_WIDTH = QVR_DATA_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [DATA_WIDTH-1:0] i_vx,
    input  logic signed [DATA_WIDTH-1:0] i_vy,
    input  logic signed [DATA_WIDTH-1:0] i_vz,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [DATA_WIDTH-1:0] o_nx,
    output logic signed [DATA_WIDTH-1:0] o_ny,
    output logic signed [DATA_WIDTH-1:0] o_nz,
    output logic                         o_zero
);

    localparam int W       = DATA_WIDTH;
    localparam int W2      = 2 * W;
    localparam int F       = W - 2;
    localparam int QB      = F + 1;
    localparam int SQW     = QVR_SQ_W;
    localparam int RW      = QVR_R_W;
    localparam int NIT     = QVR_ISQ_N;
    localparam int DW      = W + F + 2 * QVR_HK_MAX + 1;
    localparam int ST_SUM  = 1;
    localparam int ST_K    = 2;
    localparam int ST_RT0  = 3;
    localparam int ST_DIV0 = ST_RT0 + NIT;
    localparam int NS      = ST_DIV0 + QB + 1;
    localparam int K_TOP   = 2 * QVR_HK_MAX;

    typedef struct packed {
        logic                zero;
        logic [QVR_HK_W-1:0] hk;
        logic [2:0]          neg;
        logic [3*W-1:0]      mag;
    } t_side;

    logic [NS-1:0] r_vld;
    logic [NS:0]   en;
    t_side         r_side [NS];
    t_side         n_side_in, n_side_sum, n_side_k;

    logic [W2-1:0]  r_sq   [3];
    logic [W2-1:0]  n_sq   [3];
    logic [W-1:0]   n_mag  [3];
    logic signed [W-1:0] v_in [3];
    logic [SQW-1:0] r_s, n_s;
    logic [SQW-1:0] r_rx   [NIT+1];
    logic [SQW-1:0] r_rres [NIT+1];
    logic [SQW-1:0] n_rx   [NIT+1];
    logic [SQW-1:0] n_rres [NIT+1];
    logic [RW-1:0]  r_dv   [QB+1];
    logic [RW-1:0]  n_root;
    logic [RW-1:0]  r_rem  [QB+1][3];
    logic [RW-1:0]  n_rem  [QB+1][3];
    logic [QB-1:0]  r_dlo  [QB+1][3];
    logic [QB-1:0]  n_dlo0 [3];
    logic [QB-1:0]  r_quo  [QB+1][3];
    logic [QB-1:0]  n_quo  [QB+1][3];
    logic [QVR_HK_W-1:0] n_hk;
    logic [SQW-1:0] n_x0;
    logic signed [W-1:0] n_out [3];

    // stage enables: a stage loads when empty or when its successor moves
    always_comb begin
        en[NS] = i_ready;
        for (int s = NS - 1; s >= 0; s--) begin
            en[s] = !r_vld[s] || en[s+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // magnitudes and squares
    always_comb begin
        v_in[0] = i_vx;
        v_in[1] = i_vy;
        v_in[2] = i_vz;
        n_side_in = '0;
        for (int c = 0; c < 3; c++) begin
            n_mag[c] = v_in[c][W-1] ? W'(-v_in[c]) : W'(v_in[c]);
            n_sq[c]  = W2'(n_mag[c]) * W2'(n_mag[c]);
            n_side_in.neg[c] = v_in[c][W-1];
            n_side_in.mag[c*W +: W] = n_mag[c];
        end
    end

    always_comb begin
        n_s = SQW'(r_sq[0]) + SQW'(r_sq[1]) + SQW'(r_sq[2]);
        n_side_sum = r_side[ST_SUM-1];
        n_side_sum.zero = (n_s == '0);
    end

    // smallest even shift that lifts the radicand to 2^60 or above
    always_comb begin
        n_hk = QVR_HK_W'(QVR_HK_MAX);
        for (int j = QVR_HK_MAX; j >= 0; j--) begin
            if (r_s >= (SQW'(1) << (K_TOP - 2 * j))) begin
                n_hk = QVR_HK_W'(j);
            end
        end
        n_x0 = r_s << {n_hk, 1'b0};
        n_side_k = r_side[ST_K-1];
        n_side_k.hk = n_hk;
    end

    // one square-root digit per stage
    always_comb begin
        logic [SQW-1:0] v_bit;
        logic [SQW:0]   v_t;
        n_rx[0]   = '0;
        n_rres[0] = '0;
        for (int j = 0; j < NIT; j++) begin
            v_bit = SQW'(1) << (SQW - 2 - 2 * j);
            v_t   = {1'b0, r_rres[j]} + {1'b0, v_bit};
            if ({1'b0, r_rx[j]} >= v_t) begin
                n_rx[j+1]   = r_rx[j] - v_t[SQW-1:0];
                n_rres[j+1] = (r_rres[j] >> 1) + v_bit;
            end else begin
                n_rx[j+1]   = r_rx[j];
                n_rres[j+1] = r_rres[j] >> 1;
            end
        end
    end

    // dividend setup: mag * 2^(F+hk) + root/2, then one quotient bit per stage
    always_comb begin
        logic [DW-1:0] v_d;
        t_side         v_sd;
        logic [RW:0]   v_tr;
        logic          v_ge;
        v_sd   = r_side[ST_DIV0-1];
        n_root = v_sd.zero ? RW'(1) : r_rres[NIT][RW-1:0];
        for (int c = 0; c < 3; c++) begin
            v_d = (DW'(v_sd.mag[c*W +: W]) << (F + int'(v_sd.hk)))
                + DW'(r_rres[NIT][RW-1:0] >> 1);
            n_rem[0][c] = v_d[QB +: RW];
            n_dlo0[c]   = v_d[QB-1:0];
            n_quo[0][c] = '0;
        end
        for (int j = 0; j < QB; j++) begin
            for (int c = 0; c < 3; c++) begin
                v_tr = {r_rem[j][c], r_dlo[j][c][QB-1-j]};
                v_ge = (v_tr >= {1'b0, r_dv[j]});
                n_rem[j+1][c] = v_ge ? RW'(v_tr - {1'b0, r_dv[j]}) : v_tr[RW-1:0];
                n_quo[j+1][c] = {r_quo[j][c][QB-2:0], v_ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_side[0] <= n_side_in;
            for (int c = 0; c < 3; c++) begin
                r_sq[c] <= n_sq[c];
            end
        end
        for (int s = 1; s < NS; s++) begin
            if (en[s]) begin
                if (s == ST_SUM) begin
                    r_side[s] <= n_side_sum;
                end else if (s == ST_K) begin
                    r_side[s] <= n_side_k;
                end else begin
                    r_side[s] <= r_side[s-1];
                end
            end
        end
        if (en[ST_SUM]) begin
            r_s <= n_s;
        end
        if (en[ST_K]) begin
            r_rx[0]   <= n_x0;
            r_rres[0] <= '0;
        end
        for (int j = 0; j < NIT; j++) begin
            if (en[ST_RT0+j]) begin
                r_rx[j+1]   <= n_rx[j+1];
                r_rres[j+1] <= n_rres[j+1];
            end
        end
        if (en[ST_DIV0]) begin
            r_dv[0] <= n_root;
            for (int c = 0; c < 3; c++) begin
                r_rem[0][c] <= n_rem[0][c];
                r_dlo[0][c] <= n_dlo0[c];
                r_quo[0][c] <= n_quo[0][c];
            end
        end
        for (int j = 0; j < QB; j++) begin
            if (en[ST_DIV0+1+j]) begin
                r_dv[j+1] <= r_dv[j];
                for (int c = 0; c < 3; c++) begin
                    r_rem[j+1][c] <= n_rem[j+1][c];
                    r_dlo[j+1][c] <= r_dlo[j][c];
                    r_quo[j+1][c] <= n_quo[j+1][c];
                end
            end
        end
    end

    // restore sign
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_out[c] = r_side[NS-1].neg[c] ? -$signed({1'b0, r_quo[QB][c]})
                                           :  $signed({1'b0, r_quo[QB][c]});
        end
    end

    assign o_nx   = n_out[0];
    assign o_ny   = n_out[1];
    assign o_nz   = n_out[2];
    assign o_zero = r_side[NS-1].zero;

endmodule

### hw/rtl/qvr_rot.sv
// ---------------------------------------------------------------------------
// Quaternion sandwich product
// q * (0, n) * conj(q) as two multiply and round stage pairs, saturated.
// ---------------------------------------------------------------------------
module qvr_rot import qvr_pkg::*; #(
    parameter int DATA_WIDTH = QVR_DATA_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [DATA_WIDTH-1:0] i_nx,
    input  logic signed [DATA_WIDTH-1:0] i_ny,
    input  logic signed [DATA_WIDTH-1:0] i_nz,
    input  logic                         i_zero,
    input  logic signed [DATA_WIDTH-1:0] i_qw,
    input  logic signed [DATA_WIDTH-1:0] i_qx,
    input  logic signed [DATA_WIDTH-1:0] i_qy,
    input  logic signed [DATA_WIDTH-1:0] i_qz,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [DATA_WIDTH-1:0] o_x,
    output logic signed [DATA_WIDTH-1:0] o_y,
    output logic signed [DATA_WIDTH-1:0] o_z
);

    localparam int W   = DATA_WIDTH;
    localparam int F   = W - 2;
    localparam int M1W = 2 * W;
    localparam int PW  = W + 2;
    localparam int S1W = 2 * W + 2;
    localparam int M2W = 2 * W + 2;
    localparam int S3W = 2 * W + 4;
    localparam int NS  = 4;
    localparam logic signed [S1W-1:0] HALF1 = S1W'(1) << (F - 1);
    localparam logic signed [S3W-1:0] HALF3 = S3W'(1) << (F - 1);
    localparam logic signed [S3W-1:0] SAT_HI = {{(S3W-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [S3W-1:0] SAT_LO = {{(S3W-W+1){1'b1}}, {(W-1){1'b0}}};

    logic [NS-1:0] r_vld;
    logic [NS:0]   en;
    logic [NS-2:0] r_zero;

    logic signed [M1W-1:0] r_m1 [12];
    logic signed [M1W-1:0] n_m1 [12];
    logic signed [PW-1:0]  r_p  [4];
    logic signed [PW-1:0]  n_p  [4];
    logic signed [M2W-1:0] r_m2 [12];
    logic signed [M2W-1:0] n_m2 [12];
    logic signed [W-1:0]   r_o  [3];
    logic signed [W-1:0]   n_o  [3];

    function automatic logic signed [W-1:0] sat(input logic signed [S3W-1:0] v);
        logic signed [S3W-1:0] t;
        t = v >>> F;
        if (t > SAT_HI) begin
            return SAT_HI[W-1:0];
        end else if (t < SAT_LO) begin
            return SAT_LO[W-1:0];
        end
        return t[W-1:0];
    endfunction

    always_comb begin
        en[NS] = i_ready;
        for (int s = NS - 1; s >= 0; s--) begin
            en[s] = !r_vld[s] || en[s+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // first product terms
    always_comb begin
        n_m1[0]  = i_qx * i_nx;
        n_m1[1]  = i_qy * i_ny;
        n_m1[2]  = i_qz * i_nz;
        n_m1[3]  = i_qw * i_nx;
        n_m1[4]  = i_qy * i_nz;
        n_m1[5]  = i_qz * i_ny;
        n_m1[6]  = i_qw * i_ny;
        n_m1[7]  = i_qz * i_nx;
        n_m1[8]  = i_qx * i_nz;
        n_m1[9]  = i_qw * i_nz;
        n_m1[10] = i_qx * i_ny;
        n_m1[11] = i_qy * i_nx;
    end

    // first product sums, rounded half up
    always_comb begin
        logic signed [S1W-1:0] v_s [4];
        v_s[0] = -S1W'(r_m1[0]) - S1W'(r_m1[1]) - S1W'(r_m1[2]) + HALF1;
        v_s[1] =  S1W'(r_m1[3]) + S1W'(r_m1[4]) - S1W'(r_m1[5]) + HALF1;
        v_s[2] =  S1W'(r_m1[6]) + S1W'(r_m1[7]) - S1W'(r_m1[8]) + HALF1;
        v_s[3] =  S1W'(r_m1[9]) + S1W'(r_m1[10]) - S1W'(r_m1[11]) + HALF1;
        for (int i = 0; i < 4; i++) begin
            n_p[i] = v_s[i][F +: PW];
        end
    end

    // second product terms against conj(q)
    always_comb begin
        n_m2[0]  = r_p[0] * i_qx;
        n_m2[1]  = r_p[1] * i_qw;
        n_m2[2]  = r_p[2] * i_qz;
        n_m2[3]  = r_p[3] * i_qy;
        n_m2[4]  = r_p[0] * i_qy;
        n_m2[5]  = r_p[2] * i_qw;
        n_m2[6]  = r_p[3] * i_qx;
        n_m2[7]  = r_p[1] * i_qz;
        n_m2[8]  = r_p[0] * i_qz;
        n_m2[9]  = r_p[3] * i_qw;
        n_m2[10] = r_p[1] * i_qy;
        n_m2[11] = r_p[2] * i_qx;
    end

    always_comb begin
        logic signed [S3W-1:0] v_s [3];
        for (int i = 0; i < 3; i++) begin
            v_s[i] = -S3W'(r_m2[4*i]) + S3W'(r_m2[4*i+1])
                   -  S3W'(r_m2[4*i+2]) + S3W'(r_m2[4*i+3]) + HALF3;
            n_o[i] = r_zero[2] ? '0 : sat(v_s[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_zero[0] <= i_zero;
            for (int i = 0; i < 12; i++) begin
                r_m1[i] <= n_m1[i];
            end
        end
        if (en[1]) begin
            r_zero[1] <= r_zero[0];
            for (int i = 0; i < 4; i++) begin
                r_p[i] <= n_p[i];
            end
        end
        if (en[2]) begin
            r_zero[2] <= r_zero[1];
            for (int i = 0; i < 12; i++) begin
                r_m2[i] <= n_m2[i];
            end
        end
        if (en[3]) begin
            for (int i = 0; i < 3; i++) begin
                r_o[i] <= n_o[i];
            end
        end
    end

    assign o_x = r_o[0];
    assign o_y = r_o[1];
    assign o_z = r_o[2];

endmodule

### hw/rtl/quaternion_vector_rotate.sv
// ---------------------------------------------------------------------------
// Quaternion vector rotate
// Normalizes a 3-vector and rotates it by the configured quaternion.
// ---------------------------------------------------------------------------
// Takes one vector per clock and returns one rotated unit vector per clock
// for as long as the result side keeps taking transfers. The pipeline
// registers the squares, their sum and the radicand scaling, then the
// square root (one result bit per stage over a 64-bit radicand), the
// dividend setup, the three dividers (one quotient bit per stage) and the
// two quaternion products (multiply, then add and round, twice). Every
// stage carries its own valid bit and stalls only when full and blocked
// downstream, so bubbles collapse and input transfers keep flowing while a
// finished result waits in the output register. A zero vector yields zero
// outputs. The quaternion is used as written, not renormalized; outputs
// saturate to the signed range. Write q_w, q_x, q_y, q_z at byte addresses
// 0, 4, 8 and 12 while no vector is in flight.
// ---------------------------------------------------------------------------
`include "quaternion_vector_rotate_defines.svh"

module quaternion_vector_rotate import qvr_pkg::*; #(
    parameter int DATA_WIDTH = QVR_DATA_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // vector input channel
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [DATA_WIDTH-1:0] i_in_x,
    input  logic signed [DATA_WIDTH-1:0] i_in_y,
    input  logic signed [DATA_WIDTH-1:0] i_in_z,
    // result channel
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [DATA_WIDTH-1:0] o_out_x,
    output logic signed [DATA_WIDTH-1:0] o_out_y,
    output logic signed [DATA_WIDTH-1:0] o_out_z,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [QVR_ADDR_W-1:0]        paddr,
    input  logic [QVR_APB_W-1:0]         pwdata,
    output logic [QVR_APB_W-1:0]         prdata,
    output logic                         pready
);

    localparam int W = DATA_WIDTH;
    localparam int F = W - 2;

    logic [W-1:0] r_qw, r_qx, r_qy, r_qz;
    logic [1:0]   w_idx;
    logic         w_wr;

    logic                w_nv, w_nr, w_nzero;
    logic signed [W-1:0] w_nx, w_ny, w_nz;

    // ---- configuration registers -------------------------------------
    // a write lands on the access phase; pready never stalls a transfer
    assign pready = 1'b1;
    assign w_idx  = paddr[3:2];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qw <= {2'b01, {F{1'b0}}};   // 1.0 in Q2.F
            r_qx <= '0;
            r_qy <= '0;
            r_qz <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                QVR_REG_QW: r_qw <= pwdata[W-1:0];
                QVR_REG_QX: r_qx <= pwdata[W-1:0];
                QVR_REG_QY: r_qy <= pwdata[W-1:0];
                QVR_REG_QZ: r_qz <= pwdata[W-1:0];
                default:    r_qw <= r_qw;
            endcase
        end
    end

    // read back zero-extended
    always_comb begin
        unique case (w_idx)
            QVR_REG_QW: prdata = QVR_APB_W'(r_qw);
            QVR_REG_QX: prdata = QVR_APB_W'(r_qx);
            QVR_REG_QY: prdata = QVR_APB_W'(r_qy);
            QVR_REG_QZ: prdata = QVR_APB_W'(r_qz);
            default:    prdata = '0;
        endcase
    end

    // ---- datapath ----------------------------------------------------
    // normalize: |v|^2, square root, then three dividers in lockstep
    qvr_norm #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_vx    (i_in_x),
        .i_vy    (i_in_y),
        .i_vz    (i_in_z),
        .o_valid (w_nv),
        .i_ready (w_nr),
        .o_nx    (w_nx),
        .o_ny    (w_ny),
        .o_nz    (w_nz),
        .o_zero  (w_nzero)
    );

    // rotate: q * (0, n) * conj(q); last stage is the output register
    qvr_rot #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_nv),
        .o_ready (w_nr),
        .i_nx    (w_nx),
        .i_ny    (w_ny),
        .i_nz    (w_nz),
        .i_zero  (w_nzero),
        .i_qw    ($signed(r_qw)),
        .i_qx    ($signed(r_qx)),
        .i_qy    ($signed(r_qy)),
        .i_qz    ($signed(r_qz)),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_x     (o_out_x),
        .o_y     (o_out_y),
        .o_z     (o_out_z)
    );

    // ---- checks ------------------------------------------------------
    // input backpressure only comes from a full pipe behind a held result
    `QVR_ASSERT_IMP(a_stall_source, !o_ready, o_valid && !i_ready, "input stalled with room")
    // a result that was not taken stays, unchanged
    `QVR_ASSERT_NXT(a_result_hold, o_valid && !i_ready, o_valid && $stable(o_out_x) && $stable(o_out_y) && $stable(o_out_z), "held result changed")

endmodule

### bench/quaternion_vector_rotate_test.sv
// ---------------------------------------------------------------------------
// Quaternion vector rotate testbench
// Drives vectors through the rotator under several quaternions, predicts each
// rotated unit vector in fixed point and checks every result transfer in order.
// ---------------------------------------------------------------------------
module quaternion_vector_rotate_test import qvr_pkg::*;;

    localparam int DW   = QVR_DATA_WIDTH;
    localparam int FB   = DW - 2;
    localparam int LATENCY = DW + 39;

    typedef logic signed [DW-1:0] t_word;
    typedef struct packed {
        t_word x;
        t_word y;
        t_word z;
    } t_vec;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_word i_in_x, i_in_y, i_in_z;
    logic o_valid;
    logic i_ready;
    t_word o_out_x, o_out_y, o_out_z;
    logic psel, penable, pwrite;
    logic [QVR_ADDR_W-1:0] paddr;
    logic [QVR_APB_W-1:0] pwdata;
    logic [QVR_APB_W-1:0] prdata;
    logic pready;

    // Local copy of the quaternion registers
    t_word rot_q [4];
    t_vec rotated_q [$];
    int errors;
    int burst_left;
    logic stall_en;

    quaternion_vector_rotate dut (.*);

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // -----------------------------------------------------------------------
    // Prediction
    // -----------------------------------------------------------------------
    // Integer square root, floor
    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Round an exact sum to FB fraction bits, half up (floor(s/2^F + 1/2))
    function automatic longint round_fb(input longint s);
        return (s + (longint'(1) << (FB - 1))) >>> FB;
    endfunction

    function automatic t_word saturate(input longint v);
        if (v > ((longint'(1) << (DW - 1)) - 1))
            return t_word'((longint'(1) << (DW - 1)) - 1);
        if (v < -(longint'(1) << (DW - 1)))
            return t_word'(-(longint'(1) << (DW - 1)));
        return t_word'(v);
    endfunction

    function automatic longint unit_comp(input longint v, input logic [63:0] r, input int k);
        logic [63:0] mag;
        logic [63:0] num;
        longint n;
        mag = (v < 0) ? 64'(-v) : 64'(v);
        num = mag << (FB + k / 2);
        n = longint'((num + r / 2) / r);
        return (v < 0) ? -n : n;
    endfunction

    function automatic t_vec rotate_vector(input t_vec v);
        longint vx, vy, vz, qw, qx, qy, qz;
        longint nx, ny, nz, pw, px, py, pz;
        logic [63:0] s, r;
        int k;
        t_vec res;
        vx = v.x; vy = v.y; vz = v.z;
        qw = rot_q[0]; qx = rot_q[1]; qy = rot_q[2]; qz = rot_q[3];
        if (vx == 0 && vy == 0 && vz == 0) return '0;
        s = 64'(vx * vx + vy * vy + vz * vz);
        k = 0;
        while (k < 60 && s < (64'd1 << (60 - k))) k += 2;
        r = isqrt(s << k);
        nx = unit_comp(vx, r, k);
        ny = unit_comp(vy, r, k);
        nz = unit_comp(vz, r, k);
        pw = round_fb(-(qx * nx) - qy * ny - qz * nz);
        px = round_fb(qw * nx + qy * nz - qz * ny);
        py = round_fb(qw * ny + qz * nx - qx * nz);
        pz = round_fb(qw * nz + qx * ny - qy * nx);
        res.x = saturate(round_fb(-(pw * qx) + px * qw - py * qz + pz * qy));
        res.y = saturate(round_fb(-(pw * qy) + py * qw - pz * qx + px * qz));
        res.z = saturate(round_fb(-(pw * qz) + pz * qw - px * qy + py * qx));
        return res;
    endfunction

    // -----------------------------------------------------------------------
    // Result checking: stall on a free-running pattern, compare each transfer
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            // long stretches of full throughput when stall_en is low
            i_ready <= stall_en ? ($urandom_range(0, 3) != 0) : 1'b1;
            if (o_valid && i_ready) begin
                if (rotated_q.size() == 0) begin
                    $display("%0t: unexpected result %0d %0d %0d", $time,
                             o_out_x, o_out_y, o_out_z);
                    errors++;
                end else begin
                    t_vec want;
                    want = rotated_q.pop_front();
                    if (want.x !== o_out_x) begin
                        $display("%0t: out_x expected %0d actual %0d", $time, want.x, o_out_x);
                        errors++;
                    end
                    if (want.y !== o_out_y) begin
                        $display("%0t: out_y expected %0d actual %0d", $time, want.y, o_out_y);
                        errors++;
                    end
                    if (want.z !== o_out_z) begin
                        $display("%0t: out_z expected %0d actual %0d", $time, want.z, o_out_z);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (($urandom & 511) == 0) stall_en <= ~stall_en;
    end

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------
    // Send one vector; gaps fall between bursts of random length
    task automatic send_vector(input t_word x, input t_word y, input t_word z);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 2) == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_in_x  <= x;
        i_in_y  <= y;
        i_in_z  <= z;
        begin
            t_vec v;
            v.x = x; v.y = y; v.z = z;
            rotated_q.push_back(rotate_vector(v));
        end
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Lower valid, then hold until every result has come and the pipe drains
    task automatic drain;
        i_valid <= 1'b0;
        while (rotated_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input t_word val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= QVR_ADDR_W'({idx, 2'b00});
        pwdata  <= QVR_APB_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        rot_q[idx] = val;
    endtask

    task automatic set_quat(input t_word w, input t_word x, input t_word y, input t_word z);
        write_reg(QVR_REG_QW, w);
        write_reg(QVR_REG_QX, x);
        write_reg(QVR_REG_QY, y);
        write_reg(QVR_REG_QZ, z);
    endtask

    function automatic t_word rand_comp;
        case ($urandom_range(0, 5))
            0: return t_word'(int'($urandom_range(0, 15)) - 8);
            1: return $urandom_range(0, 1) ? t_word'(16'h7fff) : t_word'(16'h8000);
            default: return t_word'($urandom);
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------
    // Field extremes, zero vector, axes under the reset identity, then two more quaternions
    task automatic test_directed;
        t_word mx, mn;
        mx = t_word'(16'h7fff);
        mn = t_word'(16'h8000);
        send_vector(0, 0, 0);
        send_vector(1, 0, 0);
        send_vector(0, 1, 0);
        send_vector(0, 0, -1);
        send_vector(mx, mx, mx);
        send_vector(mn, mn, mn);
        send_vector(mn, 0, 0);
        send_vector(0, mx, 0);
        send_vector(0, 0, mn);
        send_vector(mx, mn, 1);
        send_vector(-1, -1, -1);
        send_vector(16'h5555, 16'haaaa, 16'h00ff);
        send_vector(16'haaaa, 16'h5555, 16'hff00);
        drain();
        // 90 degrees about z, then a quaternion at the register extremes
        set_quat(16'sd11585, 0, 0, 16'sd11585);
        send_vector(100, 0, 0);
        send_vector(0, 100, 0);
        send_vector(3, 4, 12);
        send_vector(0, 0, 0);
        drain();
        set_quat(mn, mx, mn, mx);
        send_vector(1, 2, 3);
        send_vector(mx, 0, mn);
        send_vector(0, 0, 0);
        drain();
    endtask

    // Random vectors under a given quaternion; sender pauses for a full drain
    task automatic test_random(input int count);
        repeat (count) send_vector(rand_comp(), rand_comp(), rand_comp());
        drain();
    endtask

    task automatic test_quaternions;
        set_quat(16'sd16384, 0, 0, 0);
        test_random(130);
        set_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
        test_random(130);
        set_quat(t_word'(16'h7fff), t_word'(16'h7fff), t_word'(16'h7fff), t_word'(16'h7fff));
        test_random(90);
        set_quat(t_word'(16'h8000), t_word'(16'h8000), t_word'(16'h8000), t_word'(16'h8000));
        test_random(90);
        set_quat(0, 0, 0, 0);
        test_random(40);
        repeat (4) begin
            set_quat(t_word'($urandom), t_word'($urandom), t_word'($urandom), t_word'($urandom));
            test_random(45);
        end
    endtask

    initial begin
        errors     = 0;
        burst_left = 0;
        stall_en   = 1'b1;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_in_x     = '0;
        i_in_y     = '0;
        i_in_z     = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        rot_q[0]   = t_word'(1 << FB);
        rot_q[1]   = '0;
        rot_q[2]   = '0;
        rot_q[3]   = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_quaternions();
        if (errors == 0)
            $display("quaternion_vector_rotate regression: pass");
        else
            $display("quaternion_vector_rotate regression: fail");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #(12 * 400000);
        $display("quaternion_vector_rotate regression: fail");
        $finish;
    end

endmodule
